// ===== rtl/core/sm4_pkg.sv =====
// Shared types, constants and round functions for the SM4 encryption core.
// No dependencies; used by sm4_block_cipher_core.
package sm4_pkg;

   localparam int NUM_ROUNDS_DEF = 32;
   localparam int CSR_INDEX_W    = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_UPPER = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LOWER = 1'b1;

   localparam logic [31:0] FK0 = 32'ha3b1bac6;
   localparam logic [31:0] FK1 = 32'h56aa3350;
   localparam logic [31:0] FK2 = 32'h677d9197;
   localparam logic [31:0] FK3 = 32'hb27022dc;

   typedef struct packed {
      logic [63:0] block_upper;
      logic [63:0] block_lower;
   } req_data_type;

   typedef struct packed {
      logic [63:0] cipher_upper;
      logic [63:0] cipher_lower;
   } rsp_data_type;

   localparam logic [7:0] SBOX_TABLE [0:255] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   function automatic logic [31:0] sub_word(input logic [31:0] v);
      sub_word = {SBOX_TABLE[v[31:24]], SBOX_TABLE[v[23:16]],
                  SBOX_TABLE[v[15:8]], SBOX_TABLE[v[7:0]]};
   endfunction

   // S-box layer followed by L (data rounds) or L' (key schedule)
   function automatic logic [31:0] t_mix(input logic [31:0] v, input logic key_mode);
      logic [31:0] b;
      logic [31:0] l_data;
      logic [31:0] l_key;
      b      = sub_word(v);
      l_data = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                 ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
      l_key  = b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
      t_mix  = key_mode ? l_key : l_data;
   endfunction

   // CK byte j of word i is (4*i + j) * 7 mod 256
   function automatic logic [31:0] ck_word(input logic [7:0] idx);
      logic [7:0] base;
      base    = {idx[5:0], 2'b00};
      ck_word = {8'(base * 8'd7), 8'((base + 8'd1) * 8'd7),
                 8'((base + 8'd2) * 8'd7), 8'((base + 8'd3) * 8'd7)};
   endfunction

endpackage

// ===== rtl/core/sm4_block_cipher_core.sv =====
// SM4 128-bit encryption core: key registers, key schedule, round-key store, round engine.
// Depends on sm4_pkg.
// One round per cycle through a single shared S-box/linear-transform unit; the result then
//   passes through ST_OUTPUT into the output register, waiting there while rsp_stall holds it.
// A new transaction is taken only after the last one leaves ST_OUTPUT; req_stall stays high while a block is in work.
// Reset: synchronous; clears both key registers and runs the key schedule,
//   req_stall high meanwhile. Every key write reruns the same schedule.
module sm4_block_cipher_core #(
   parameter int NUM_ROUNDS = sm4_pkg::NUM_ROUNDS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  sm4_pkg::req_data_type             req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output sm4_pkg::rsp_data_type             rsp_data,
   input  logic                              csr_write_en,
   input  logic [sm4_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [63:0]                       csr_wdata
);

   localparam int RND_W = $clog2(NUM_ROUNDS);
   localparam logic [RND_W-1:0] LAST_RND = RND_W'(NUM_ROUNDS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_KEY,
      ST_ROUND,
      ST_OUTPUT
   } state_type;

   state_type             state_ff, state_in;
   logic [RND_W-1:0]      cnt_ff, cnt_in;
   logic                  pend_ff, pend_in;
   logic [63:0]           key_upper_ff, key_upper_in;
   logic [63:0]           key_lower_ff, key_lower_in;
   logic [31:0]           word_ff [4];
   logic [31:0]           word_in [4];
   logic                  rsp_valid_ff, rsp_valid_in;
   sm4_pkg::rsp_data_type rsp_data_ff, rsp_data_in;
   logic [31:0]           rk_ff [NUM_ROUNDS];
   logic                  rk_we;

   logic                  csr_hit;
   logic                  req_accept;
   logic                  rsp_free;
   logic [31:0]           addend;
   logic [31:0]           unit_out;

   assign req_stall  = (state_ff != ST_IDLE) || pend_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign addend   = (state_ff == ST_KEY) ? sm4_pkg::ck_word(8'(cnt_ff)) : rk_ff[cnt_ff];
   assign unit_out = word_ff[0] ^ sm4_pkg::t_mix(word_ff[1] ^ word_ff[2] ^ word_ff[3] ^ addend,
                                                 state_ff == ST_KEY);

   always_comb begin
      key_upper_in = key_upper_ff;
      key_lower_in = key_lower_ff;
      csr_hit      = 1'b0;
      if (csr_write_en) begin
         case (csr_index)
            sm4_pkg::CSR_KEY_UPPER: begin
               key_upper_in = csr_wdata;
               csr_hit      = 1'b1;
            end
            sm4_pkg::CSR_KEY_LOWER: begin
               key_lower_in = csr_wdata;
               csr_hit      = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff || csr_hit;
      word_in      = word_ff;
      rk_we        = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE, ST_KEY: begin
            if (pend_ff) begin
               word_in[0] = key_upper_ff[63:32] ^ sm4_pkg::FK0;
               word_in[1] = key_upper_ff[31:0]  ^ sm4_pkg::FK1;
               word_in[2] = key_lower_ff[63:32] ^ sm4_pkg::FK2;
               word_in[3] = key_lower_ff[31:0]  ^ sm4_pkg::FK3;
               cnt_in     = '0;
               pend_in    = csr_hit;
               state_in   = ST_KEY;
            end else if (state_ff == ST_KEY) begin
               word_in[0] = word_ff[1];
               word_in[1] = word_ff[2];
               word_in[2] = word_ff[3];
               word_in[3] = unit_out;
               rk_we      = 1'b1;
               cnt_in     = RND_W'(cnt_ff + 1'b1);
               if (cnt_ff == LAST_RND) begin
                  state_in = ST_IDLE;
               end
            end else if (req_accept) begin
               word_in[0] = req_data.block_upper[63:32];
               word_in[1] = req_data.block_upper[31:0];
               word_in[2] = req_data.block_lower[63:32];
               word_in[3] = req_data.block_lower[31:0];
               cnt_in     = '0;
               state_in   = ST_ROUND;
            end
         end
         ST_ROUND: begin
            word_in[0] = word_ff[1];
            word_in[1] = word_ff[2];
            word_in[2] = word_ff[3];
            word_in[3] = unit_out;
            cnt_in     = RND_W'(cnt_ff + 1'b1);
            if (cnt_ff == LAST_RND) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (rsp_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.cipher_upper = {word_ff[3], word_ff[2]};
               rsp_data_in.cipher_lower = {word_ff[1], word_ff[0]};
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b1;
         key_upper_ff <= '0;
         key_lower_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         key_upper_ff <= key_upper_in;
         key_lower_ff <= key_lower_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff     <= word_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (rk_we) begin
         rk_ff[cnt_ff] <= unit_out;
      end
   end

   a_accept_starts_rounds: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_ROUND) && (cnt_ff == '0))
      else $error("accepted transaction did not start at round zero");

   a_round_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) && (cnt_ff != LAST_RND)
      |=> (state_ff == ST_ROUND) && (cnt_ff == RND_W'($past(cnt_ff) + 1'b1)))
      else $error("round counter did not advance");

   a_schedule_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_KEY) && !pend_ff && (cnt_ff == LAST_RND) && !csr_hit
      |=> (state_ff == ST_IDLE) && !pend_ff)
      else $error("key schedule did not finish after the last round key");

   a_rsp_from_output: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUTPUT))
      else $error("result raised outside the output state");

endmodule

// ===== tb/sv/sm4_cipher_checker.sv =====
// Checker for sm4_block_cipher_core: tracks key writes, predicts ciphertexts, compares results.
// Depends on sm4_pkg for the request and response payload types and the key register indexes.
module sm4_cipher_checker
   import sm4_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  req_data_type              req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  rsp_data_type              rsp_data,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [63:0]               csr_wdata,
   output int                        mismatch_count,
   output int                        blocks_in_flight,
   output int                        ciphertexts_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROUNDS     = NUM_ROUNDS_DEF;
   localparam int REPORT_CAP = 50;

   localparam logic [7:0] sbox_lut [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   localparam logic [31:0] fk_word [4] = '{
      32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
   };

   logic [63:0]  key_hi;
   logic [63:0]  key_lo;
   logic [31:0]  round_keys [ROUNDS];
   rsp_data_type ciphertext_q [$];
   int           errors  = 0;
   int           checked = 0;

   function automatic logic [31:0] substitute(input logic [31:0] w);
      return {sbox_lut[w[31:24]], sbox_lut[w[23:16]], sbox_lut[w[15:8]], sbox_lut[w[7:0]]};
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] w, input int n);
      return (w << n) | (w >> (32 - n));
   endfunction

   function automatic logic [31:0] data_mix(input logic [31:0] w);
      logic [31:0] b;
      b = substitute(w);
      return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
   endfunction

   function automatic logic [31:0] key_mix(input logic [31:0] w);
      logic [31:0] b;
      b = substitute(w);
      return b ^ rotl(b, 13) ^ rotl(b, 23);
   endfunction

   function automatic logic [31:0] ck_const(input int i);
      logic [31:0] w;
      w = '0;
      for (int j = 0; j < 4; j++) begin
         w = {w[23:0], 8'((4 * i + j) * 7)};
      end
      return w;
   endfunction

   function automatic void expand_round_keys();
      logic [31:0] k [4];
      logic [31:0] nk;
      k[0] = key_hi[63:32] ^ fk_word[0];
      k[1] = key_hi[31:0]  ^ fk_word[1];
      k[2] = key_lo[63:32] ^ fk_word[2];
      k[3] = key_lo[31:0]  ^ fk_word[3];
      for (int i = 0; i < ROUNDS; i++) begin
         nk = k[0] ^ key_mix(k[1] ^ k[2] ^ k[3] ^ ck_const(i));
         round_keys[i] = nk;
         k[0] = k[1];
         k[1] = k[2];
         k[2] = k[3];
         k[3] = nk;
      end
   endfunction

   function automatic rsp_data_type encrypt_block(input req_data_type blk);
      logic [31:0]  x [4];
      logic [31:0]  nx;
      rsp_data_type ct;
      x[0] = blk.block_upper[63:32];
      x[1] = blk.block_upper[31:0];
      x[2] = blk.block_lower[63:32];
      x[3] = blk.block_lower[31:0];
      for (int i = 0; i < ROUNDS; i++) begin
         nx = x[0] ^ data_mix(x[1] ^ x[2] ^ x[3] ^ round_keys[i]);
         x[0] = x[1];
         x[1] = x[2];
         x[2] = x[3];
         x[3] = nx;
      end
      ct.cipher_upper = {x[3], x[2]};
      ct.cipher_lower = {x[1], x[0]};
      return ct;
   endfunction

   task automatic report_mismatch(input string msg);
      if (errors < REPORT_CAP) begin
         $display("%0t ERROR %s", $time, msg);
      end
      errors++;
   endtask

   always @(posedge clock) begin : watch
      rsp_data_type want;
      if (reset) begin
         key_hi = '0;
         key_lo = '0;
         expand_round_keys();
         ciphertext_q.delete();
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_KEY_UPPER) begin
               key_hi = csr_wdata;
            end else if (csr_index == CSR_KEY_LOWER) begin
               key_lo = csr_wdata;
            end
            expand_round_keys();
         end
         if (req_valid && !req_stall) begin
            ciphertext_q.push_back(encrypt_block(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (ciphertext_q.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction %h", rsp_data));
            end else begin
               want = ciphertext_q.pop_front();
               checked++;
               if (rsp_data.cipher_upper !== want.cipher_upper) begin
                  report_mismatch($sformatf("cipher_upper %h, expected %h",
                                            rsp_data.cipher_upper, want.cipher_upper));
               end
               if (rsp_data.cipher_lower !== want.cipher_lower) begin
                  report_mismatch($sformatf("cipher_lower %h, expected %h",
                                            rsp_data.cipher_lower, want.cipher_lower));
               end
            end
         end
      end
      mismatch_count      <= errors;
      blocks_in_flight    <= ciphertext_q.size();
      ciphertexts_checked <= checked;
   end

endmodule

// ===== tb/sv/tb_sm4_block_cipher_core.sv =====
// Testbench top for sm4_block_cipher_core: clock, reset, key writes, block stimulus, verdict.
// Depends on sm4_pkg, sm4_block_cipher_core and sm4_cipher_checker.
module tb_sm4_block_cipher_core;
   timeunit 1ns;
   timeprecision 1ps;
   import sm4_pkg::*;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int SCHEDULE_WAIT  = 40;
   localparam int END_WAIT       = 40;
   localparam int HOLD_CYCLES    = 400;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 130;

   logic                   clock;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_stall;
   req_data_type           req_data     = '0;
   logic                   rsp_valid;
   logic                   rsp_stall    = 1'b0;
   rsp_data_type           rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = '0;
   logic [63:0]            csr_wdata    = '0;

   int  mismatch_count;
   int  blocks_in_flight;
   int  ciphertexts_checked;
   int  cycle_count  = 0;
   int  blocks_sent  = 0;
   int  key_writes   = 0;
   int  holds_asked  = 0;
   int  holds_taken  = 0;
   bit  req_idle_on  = 1'b1;
   bit  rsp_idle_on  = 1'b1;

   sm4_block_cipher_core DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   sm4_cipher_checker cipher_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data            (req_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_data            (rsp_data),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .mismatch_count      (mismatch_count),
      .blocks_in_flight    (blocks_in_flight),
      .ciphertexts_checked (ciphertexts_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d blocks still in flight",
                  cycle_count, blocks_in_flight);
         $display("status: fail");
         $finish;
      end
   end

   // receiver: random stall per transaction while rsp_idle_on is set, plus one long hold on request
   initial begin : receiver
      int wait_cycles;
      forever begin
         if (holds_taken != holds_asked) begin
            holds_taken = holds_asked;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         wait_cycles = rsp_idle_on ? $urandom_range(0, 14) : 0;
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic logic [63:0] rand_field();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   task automatic send_block(input req_data_type blk);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= blk;
      do @(posedge clock); while (req_stall);
      blocks_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (blocks_in_flight != 0);
   endtask

   task automatic write_key_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] value);
      drain_results();
      repeat (SCHEDULE_WAIT) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      key_writes++;
   endtask

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_block({64'h0, 64'h0});
      send_block({64'hffffffffffffffff, 64'hffffffffffffffff});
      send_block({64'h0123456789abcdef, 64'hfedcba9876543210});
      send_block({64'h5555555555555555, 64'haaaaaaaaaaaaaaaa});
      send_block({64'h0, 64'h1});
      send_block({64'h8000000000000000, 64'h0});

      write_key_reg(CSR_KEY_UPPER, 64'h0123456789abcdef);
      write_key_reg(CSR_KEY_LOWER, 64'hfedcba9876543210);
      send_block({64'h0123456789abcdef, 64'hfedcba9876543210});
      send_block({64'h0, 64'h0});
      send_block({64'hffffffffffffffff, 64'hffffffffffffffff});

      // partial update: upper half only, then the lower half
      write_key_reg(CSR_KEY_UPPER, 64'hffffffffffffffff);
      send_block({64'h0123456789abcdef, 64'hfedcba9876543210});
      send_block({64'haaaaaaaaaaaaaaaa, 64'h5555555555555555});
      write_key_reg(CSR_KEY_LOWER, 64'hffffffffffffffff);
      send_block({64'h0, 64'h0});
      send_block({64'hffffffffffffffff, 64'hffffffffffffffff});

      write_key_reg(CSR_KEY_UPPER, 64'h0);
      write_key_reg(CSR_KEY_LOWER, 64'h0);
      send_block({64'h0123456789abcdef, 64'hfedcba9876543210});
      send_block({64'hffff0000ffff0000, 64'h0000ffff0000ffff});

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            2: write_key_reg(CSR_KEY_UPPER, rand_field());
            5: write_key_reg(CSR_KEY_LOWER, rand_field());
            4: begin
               write_key_reg(CSR_KEY_UPPER, 64'h0);
               write_key_reg(CSR_KEY_LOWER, 64'h0);
            end
            7: begin
               write_key_reg(CSR_KEY_UPPER, 64'hffffffffffffffff);
               write_key_reg(CSR_KEY_LOWER, 64'hffffffffffffffff);
            end
            default: begin
               write_key_reg(CSR_KEY_UPPER, rand_field());
               write_key_reg(CSR_KEY_LOWER, rand_field());
            end
         endcase
         req_idle_on = phase[0];
         rsp_idle_on = phase[1];
         if (phase == 3) begin
            holds_asked++;
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (phase == 6 && i == PHASE_ITEMS / 2) begin
               drain_results();
            end
            send_block({rand_field(), rand_field()});
         end
      end

      drain_results();
      repeat (END_WAIT) @(posedge clock);

      $display("covered %0d blocks across %0d key register writes, %0d ciphertexts compared",
               blocks_sent, key_writes, ciphertexts_checked);
      $display("mismatches: %0d", mismatch_count);
      if (mismatch_count == 0 && blocks_in_flight == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/sm4_pkg.sv
rtl/core/sm4_block_cipher_core.sv
tb/sv/sm4_cipher_checker.sv
tb/sv/tb_sm4_block_cipher_core.sv
